@@ sv/svpm_pkg.sv @@
// Shared widths, codes, control types and the microprogram of the Sv39 page map.
package svpm_pkg;

  localparam int DEF_POOL_PAGES = 16;
  localparam int DEF_LEVELS     = 3;

  localparam int INDEX_BITS  = 9;
  localparam int ENTRIES     = 1 << INDEX_BITS;
  localparam int PAGE_SHIFT  = 12;
  localparam int ENTRY_W     = 64;
  localparam int PPN_W       = 44;
  localparam int PPN_SHIFT   = 10;
  localparam int VA_W        = 39;
  localparam int FLAGS_W     = 10;
  localparam int STATUS_W    = 2;
  localparam int MADE_W      = 2;
  localparam int POOL_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 44;
  localparam int ROOT_PAGE   = 1;
  localparam int FIRST_FREE  = 3;
  localparam int POOL_RESET  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PPN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd2;

  localparam int STEP_W = 4;
  localparam int ACT_W  = 4;
  localparam int COND_W = 3;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [COND_W-1:0] cond_t;

  localparam step_t STEP_CLR      = 4'd0;
  localparam step_t STEP_IDLE     = 4'd1;
  localparam step_t STEP_DISPATCH = 4'd2;
  localparam step_t STEP_MAP_DATA = 4'd3;
  localparam step_t STEP_WALK     = 4'd4;
  localparam step_t STEP_CHECK    = 4'd5;
  localparam step_t STEP_MISS     = 4'd6;
  localparam step_t STEP_MAKE     = 4'd7;
  localparam step_t STEP_LEAF     = 4'd8;
  localparam step_t STEP_DONE     = 4'd9;

  localparam act_t ACT_NONE       = 4'd0;
  localparam act_t ACT_CLR        = 4'd1;
  localparam act_t ACT_LATCH      = 4'd2;
  localparam act_t ACT_TAKE_DATA  = 4'd3;
  localparam act_t ACT_READ       = 4'd4;
  localparam act_t ACT_DESCEND    = 4'd5;
  localparam act_t ACT_MAKE_TABLE = 4'd6;
  localparam act_t ACT_WRITE_LEAF = 4'd7;
  localparam act_t ACT_FAIL_OOP   = 4'd8;
  localparam act_t ACT_FAIL_NM    = 4'd9;
  localparam act_t ACT_EMIT       = 4'd10;

  localparam cond_t COND_ALWAYS   = 3'd0;
  localparam cond_t COND_IN_ACC   = 3'd1;
  localparam cond_t COND_CLR_LAST = 3'd2;
  localparam cond_t COND_UNMAP    = 3'd3;
  localparam cond_t COND_NO_FREE  = 3'd4;
  localparam cond_t COND_LAST_LVL = 3'd5;
  localparam cond_t COND_ENTRY_OK = 3'd6;
  localparam cond_t COND_OUT_BUSY = 3'd7;

  typedef struct packed {
    cond_t cond;
    act_t  act_tr;
    step_t tgt_tr;
    act_t  act_f;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    act_t act;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic clr_last;
    logic unmap;
    logic no_free;
    logic last_lvl;
    logic entry_ok;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      STEP_CLR:      w = '{COND_CLR_LAST, ACT_CLR, STEP_IDLE, ACT_CLR, STEP_CLR};
      STEP_IDLE:     w = '{COND_IN_ACC, ACT_LATCH, STEP_DISPATCH, ACT_NONE, STEP_IDLE};
      STEP_DISPATCH: w = '{COND_UNMAP, ACT_NONE, STEP_WALK, ACT_NONE, STEP_MAP_DATA};
      STEP_MAP_DATA: w = '{COND_NO_FREE, ACT_FAIL_OOP, STEP_DONE, ACT_TAKE_DATA, STEP_WALK};
      STEP_WALK:     w = '{COND_LAST_LVL, ACT_NONE, STEP_LEAF, ACT_READ, STEP_CHECK};
      STEP_CHECK:    w = '{COND_ENTRY_OK, ACT_DESCEND, STEP_WALK, ACT_NONE, STEP_MISS};
      STEP_MISS:     w = '{COND_UNMAP, ACT_FAIL_NM, STEP_DONE, ACT_NONE, STEP_MAKE};
      STEP_MAKE:     w = '{COND_NO_FREE, ACT_FAIL_OOP, STEP_DONE, ACT_MAKE_TABLE, STEP_WALK};
      STEP_LEAF:     w = '{COND_ALWAYS, ACT_WRITE_LEAF, STEP_DONE, ACT_NONE, STEP_DONE};
      STEP_DONE:     w = '{COND_OUT_BUSY, ACT_NONE, STEP_DONE, ACT_EMIT, STEP_IDLE};
      default:       w = '{COND_ALWAYS, ACT_NONE, STEP_IDLE, ACT_NONE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/svpm_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration writes.
interface svpm_in_if;
  import svpm_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [VA_W-1:0]    virt_addr;
  logic [FLAGS_W-1:0] leaf_flags;
  modport source (output valid, output mode, output virt_addr, output leaf_flags,
                  input ready);
  modport sink   (input valid, input mode, input virt_addr, input leaf_flags,
                  output ready);
endinterface

interface svpm_out_if;
  import svpm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PPN_W-1:0]    page_ppn;
  logic [MADE_W-1:0]   tables_made;
  modport source (output valid, output status, output page_ppn, output tables_made,
                  input ready);
  modport sink   (input valid, input status, input page_ppn, input tables_made,
                  output ready);
endinterface

interface svpm_cfg_if;
  import svpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/svpm_seq.sv @@
// Microcode sequencer: step counter, control word table and conditional jumps.
module svpm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  svpm_pkg::flags_t flags,
  output svpm_pkg::ctrl_t  ctrl
);
  import svpm_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t word_w;
  logic   cond_w;

  assign word_w = ucode(step_r);

  always_comb begin
    unique case (word_w.cond)
      COND_ALWAYS:   cond_w = 1'b1;
      COND_IN_ACC:   cond_w = flags.in_acc;
      COND_CLR_LAST: cond_w = flags.clr_last;
      COND_UNMAP:    cond_w = flags.unmap;
      COND_NO_FREE:  cond_w = flags.no_free;
      COND_LAST_LVL: cond_w = flags.last_lvl;
      COND_ENTRY_OK: cond_w = flags.entry_ok;
      COND_OUT_BUSY: cond_w = flags.out_busy;
      default:       cond_w = 1'b0;
    endcase
  end

  assign step_nxt  = cond_w ? word_w.tgt_tr : word_w.tgt_f;
  assign ctrl.act  = cond_w ? word_w.act_tr : word_w.act_f;
  assign ctrl.idle = (step_r == STEP_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ sv/svpm_dp.sv @@
// Datapath: configuration, page allocator, walk registers, table memory and result register.
module svpm_dp #(
  parameter int POOL_PAGES = svpm_pkg::DEF_POOL_PAGES,
  parameter int LEVELS     = svpm_pkg::DEF_LEVELS
) (
  input  logic             clk,
  input  logic             rst_n,
  svpm_in_if.sink          in_ch,
  svpm_out_if.source       out_ch,
  svpm_cfg_if.sink         cfg_ch,
  input  svpm_pkg::ctrl_t  ctrl,
  output svpm_pkg::flags_t flags
);
  import svpm_pkg::*;

  localparam int PG_W   = $clog2(POOL_PAGES);
  localparam int NF_W   = $clog2(POOL_PAGES + 1);
  localparam int CMP_W  = (NF_W > POOL_W) ? NF_W : POOL_W;
  localparam int LV_W   = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int DEPTH  = POOL_PAGES * ENTRIES;
  localparam int ADDR_W = PG_W + INDEX_BITS;
  localparam int WALK_W = PAGE_SHIFT + LEVELS * INDEX_BITS;
  localparam int VX_W   = (WALK_W > VA_W) ? WALK_W : VA_W;
  localparam int PAD_W  = ENTRY_W - PPN_W - PPN_SHIFT;

  logic [PPN_W-1:0]    base_ppn_r;
  logic [POOL_W-1:0]   pool_pages_r;
  logic [NF_W-1:0]     nf_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic                out_valid_r;

  logic                mode_r;
  logic [VA_W-1:0]     va_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [STATUS_W-1:0] status_r;
  logic [MADE_W-1:0]   made_r;
  logic [PPN_W-1:0]    ppn_res_r;
  logic [PG_W-1:0]     cur_r;
  logic [LV_W-1:0]     level_r;
  logic [PG_W-1:0]     data_pg_r;
  logic [ENTRY_W-1:0]  rd_q_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PPN_W-1:0]    out_ppn_r;
  logic [MADE_W-1:0]   out_made_r;

  logic [ENTRY_W-1:0]  tbl_mem [DEPTH];

  logic [CMP_W-1:0]      pool_use_w;
  logic                  no_free_w;
  logic [VX_W-1:0]       va_x_w;
  logic [INDEX_BITS-1:0] idx_w;
  logic [ADDR_W-1:0]     slot_w;
  logic [PPN_W-1:0]      off_w;
  logic [PPN_W-1:0]      nf_ppn_w;
  logic [PPN_W-1:0]      data_ppn_w;
  logic                  wr_en_w;
  logic [ADDR_W-1:0]     wr_addr_w;
  logic [ENTRY_W-1:0]    wr_data_w;

  always_comb begin
    if (CMP_W'(pool_pages_r) > CMP_W'(POOL_PAGES)) begin
      pool_use_w = CMP_W'(POOL_PAGES);
    end else begin
      pool_use_w = CMP_W'(pool_pages_r);
    end
  end

  assign no_free_w = (CMP_W'(nf_r) >= pool_use_w);
  assign va_x_w    = VX_W'(va_r);

  always_comb begin
    idx_w = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (level_r == LV_W'(l)) begin
        idx_w = va_x_w[PAGE_SHIFT + (LEVELS - 1 - l) * INDEX_BITS +: INDEX_BITS];
      end
    end
  end

  assign slot_w     = {cur_r, idx_w};
  assign off_w      = rd_q_r[PPN_SHIFT +: PPN_W] - base_ppn_r;
  assign nf_ppn_w   = base_ppn_r + PPN_W'(nf_r);
  assign data_ppn_w = base_ppn_r + PPN_W'(data_pg_r);

  assign flags.in_acc   = in_ch.valid && ctrl.idle;
  assign flags.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign flags.unmap    = mode_r;
  assign flags.no_free  = no_free_w;
  assign flags.last_lvl = (level_r == LV_W'(LEVELS - 1));
  assign flags.entry_ok = rd_q_r[0] && (off_w < PPN_W'(pool_use_w));
  assign flags.out_busy = out_valid_r && !out_ch.ready;

  always_comb begin
    wr_en_w   = 1'b0;
    wr_addr_w = slot_w;
    wr_data_w = '0;
    unique case (ctrl.act)
      ACT_CLR: begin
        wr_en_w   = 1'b1;
        wr_addr_w = clr_addr_r;
      end
      ACT_MAKE_TABLE: begin
        wr_en_w   = 1'b1;
        wr_data_w = {{PAD_W{1'b0}}, nf_ppn_w, {(PPN_SHIFT - 1){1'b0}}, 1'b1};
      end
      ACT_WRITE_LEAF: begin
        wr_en_w = 1'b1;
        if (!mode_r) begin
          wr_data_w = {{PAD_W{1'b0}}, data_ppn_w, flags_r[FLAGS_W-1:1], 1'b1};
        end
      end
      default: begin
        wr_en_w = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en_w) begin
      tbl_mem[wr_addr_w] <= wr_data_w;
    end
    if (ctrl.act == ACT_READ) begin
      rd_q_r <= tbl_mem[slot_w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ppn_r   <= '0;
      pool_pages_r <= POOL_W'(POOL_RESET);
      nf_r         <= NF_W'(FIRST_FREE);
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_BASE_PPN:   base_ppn_r   <= cfg_ch.data[PPN_W-1:0];
          CFG_POOL_PAGES: pool_pages_r <= cfg_ch.data[POOL_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.act == ACT_CLR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if ((ctrl.act == ACT_TAKE_DATA) || (ctrl.act == ACT_MAKE_TABLE)) begin
        nf_r <= nf_r + NF_W'(1);
      end
      if (ctrl.act == ACT_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_LATCH: begin
        mode_r    <= in_ch.mode;
        va_r      <= in_ch.virt_addr;
        flags_r   <= in_ch.leaf_flags;
        status_r  <= ST_OK;
        made_r    <= '0;
        ppn_res_r <= '0;
        cur_r     <= PG_W'(ROOT_PAGE);
        level_r   <= '0;
      end
      ACT_TAKE_DATA: begin
        data_pg_r <= nf_r[PG_W-1:0];
      end
      ACT_DESCEND: begin
        cur_r   <= off_w[PG_W-1:0];
        level_r <= level_r + LV_W'(1);
      end
      ACT_MAKE_TABLE: begin
        cur_r   <= nf_r[PG_W-1:0];
        level_r <= level_r + LV_W'(1);
        made_r  <= made_r + MADE_W'(1);
      end
      ACT_WRITE_LEAF: begin
        if (!mode_r) begin
          ppn_res_r <= data_ppn_w;
        end
      end
      ACT_FAIL_OOP: status_r <= ST_NO_PAGES;
      ACT_FAIL_NM:  status_r <= ST_NOT_MAPPED;
      ACT_EMIT: begin
        out_status_r <= status_r;
        out_ppn_r    <= ppn_res_r;
        out_made_r   <= made_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready        = ctrl.idle;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.page_ppn    = out_ppn_r;
  assign out_ch.tables_made = out_made_r;

endmodule

@@ sv/sv39_page_map_with_pool_core.sv @@
// Top level of the Sv39 page map that builds its tables in a fixed pool of pages.
//
//   Channel  Dir  Beat contents
//   in_ch    in   mode, virt_addr, leaf_flags
//   out_ch   out  status, page_ppn, tables_made
//   cfg_ch   in   index (0 base_ppn, 1 pool_pages), data
//
// One request at a time; a map first takes a data page from the pool and an unmap does not,
// then both walk with one table read for each level above the leaf through the table
// memory read port, each read followed by a check step. After reset a clearing pass writes
// zero to all POOL_PAGES*512 entries, one per cycle, before in_ch.ready first rises. A
// finished result waits in the output register while the next request is taken; the
// sequencer stalls only when a new result finds it full.
module sv39_page_map_with_pool_core #(
  parameter int POOL_PAGES = svpm_pkg::DEF_POOL_PAGES,
  parameter int LEVELS     = svpm_pkg::DEF_LEVELS
) (
  input  logic       clk,
  input  logic       rst_n,
  svpm_in_if.sink    in_ch,
  svpm_out_if.source out_ch,
  svpm_cfg_if.sink   cfg_ch
);
  import svpm_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  svpm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  svpm_dp #(
    .POOL_PAGES (POOL_PAGES),
    .LEVELS     (LEVELS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .ctrl   (ctrl),
    .flags  (flags)
  );

endmodule

@@ sv/svpm_checker.sv @@
// Port-level assertions for the page map core and the bind that attaches them.
module svpm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [svpm_pkg::STATUS_W-1:0] out_status,
  input logic [svpm_pkg::PPN_W-1:0]    out_page_ppn,
  input logic [svpm_pkg::MADE_W-1:0]   out_tables_made
);
  import svpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_fail_no_ppn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_page_ppn == '0))
    else $error("failed request reports a page");

  a_unmapped_no_tables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_MAPPED) |-> (out_tables_made == '0))
    else $error("not-mapped result reports new tables");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one is in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken before table clearing");

endmodule

bind sv39_page_map_with_pool_core svpm_checker u_svpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_page_ppn    (out_ch.page_ppn),
  .out_tables_made (out_ch.tables_made)
);
